// ----- src/dmxrdm_pkg.sv -----
`default_nettype none

package dmxrdm_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 10;
  localparam int unsigned MinW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CountW-1:0] SlotLimit      = 10'd512;
  localparam logic [CountW-1:0] RdmLenIndex    = 10'd2;
  localparam logic [CountW-1:0] RdmChecksumLen = 10'd2;

  localparam logic [ByteW-1:0]  DmxStartCodeRst = 8'd0;
  localparam logic [ByteW-1:0]  RdmStartCodeRst = 8'd204;
  localparam logic [CountW-1:0] MaxSlotsRst     = 10'd512;
  localparam logic [MinW-1:0]   RdmMinLenRst    = 9'd26;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DMX_START_CODE = 2'd0,
    CFG_RDM_START_CODE = 2'd1,
    CFG_MAX_SLOTS      = 2'd2,
    CFG_RDM_MIN_LENGTH = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_START = 2'd1,
    MODE_SLOTS = 2'd2,
    MODE_RDM   = 2'd3
  } rx_mode_e;

  typedef enum logic [2:0] {
    EV_IGNORED      = 3'd0,
    EV_START_STORED = 3'd1,
    EV_SLOT_STORED  = 3'd2,
    EV_DMX_DONE     = 3'd3,
    EV_RDM_DONE     = 3'd4,
    EV_BREAK_FLUSH  = 3'd5,
    EV_BREAK_IDLE   = 3'd6,
    EV_OVERRUN      = 3'd7
  } event_e;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    logic             is_break;
    logic             is_overrun;
  } rx_item_t;

  typedef struct packed {
    event_e            event_res;
    logic [CountW-1:0] slot_index;
    logic [ByteW-1:0]  slot_data;
  } rx_result_t;

endpackage

`default_nettype wire

// ----- src/dmxrdm_in_stage.sv -----
`default_nettype none

module dmxrdm_in_stage
  import dmxrdm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire rx_item_t item_i,
  output logic          valid_o,
  input  wire logic     take_i,
  output rx_item_t      item_o
);

  logic     valid_q, valid_d;
  rx_item_t item_q;

  // refill in the same cycle that the held transaction moves on
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ----- src/dmxrdm_framer.sv -----
`default_nettype none

module dmxrdm_framer
  import dmxrdm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                advance_i,
  input  wire rx_item_t            item_i,
  output rx_result_t               result_o
);

  logic [ByteW-1:0]  dmx_code_q, rdm_code_q;
  logic [CountW-1:0] max_slots_q;
  logic [MinW-1:0]   rdm_min_q;

  rx_mode_e          mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [ByteW-1:0]  rdm_len_q, rdm_len_d;

  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] slot_lim;
  logic [ByteW-1:0]  len_eff;
  cfg_reg_e          cfg_sel;

  assign cfg_sel = cfg_reg_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dmx_code_q  <= DmxStartCodeRst;
      rdm_code_q  <= RdmStartCodeRst;
      max_slots_q <= MaxSlotsRst;
      rdm_min_q   <= RdmMinLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        CFG_DMX_START_CODE: dmx_code_q  <= cfg_data_i[ByteW-1:0];
        CFG_RDM_START_CODE: rdm_code_q  <= cfg_data_i[ByteW-1:0];
        CFG_MAX_SLOTS:      max_slots_q <= cfg_data_i[CountW-1:0];
        CFG_RDM_MIN_LENGTH: rdm_min_q   <= cfg_data_i[MinW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      count_q   <= '0;
      rdm_len_q <= '0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      count_q   <= count_d;
      rdm_len_q <= rdm_len_d;
    end
  end

  assign count_inc = count_q + 10'd1;
  assign slot_lim  = (max_slots_q > SlotLimit) ? SlotLimit : max_slots_q;
  // the length byte counts as soon as it arrives
  assign len_eff   = (count_q == RdmLenIndex) ? item_i.rx_byte : rdm_len_q;

  always_comb begin
    mode_d    = mode_q;
    count_d   = count_q;
    rdm_len_d = rdm_len_q;
    result_o  = '{event_res: EV_IGNORED, slot_index: '0, slot_data: '0};
    priority if (item_i.is_overrun) begin
      result_o.event_res = EV_OVERRUN;
    end else if (item_i.is_break) begin
      result_o.event_res = (count_q != '0) ? EV_BREAK_FLUSH : EV_BREAK_IDLE;
      count_d = '0;
      mode_d  = MODE_START;
    end else begin
      unique case (mode_q)
        MODE_START: begin
          count_d   = 10'd1;
          rdm_len_d = '0;
          priority if (item_i.rx_byte == dmx_code_q) begin
            mode_d = MODE_SLOTS;
          end else if (item_i.rx_byte == rdm_code_q) begin
            mode_d = MODE_RDM;
          end else begin
            mode_d = MODE_IDLE;
          end
          result_o.event_res = EV_START_STORED;
          result_o.slot_data = item_i.rx_byte;
        end
        MODE_SLOTS: begin
          result_o.slot_index = count_q;
          result_o.slot_data  = item_i.rx_byte;
          if (count_inc > slot_lim) begin
            result_o.event_res = EV_DMX_DONE;
            count_d = '0;
            mode_d  = MODE_IDLE;
          end else begin
            result_o.event_res = EV_SLOT_STORED;
            count_d = count_inc;
          end
        end
        MODE_RDM: begin
          rdm_len_d           = len_eff;
          result_o.slot_index = count_q;
          result_o.slot_data  = item_i.rx_byte;
          if ((count_inc >= (CountW'(len_eff) + RdmChecksumLen)) &&
              (count_inc >= CountW'(rdm_min_q))) begin
            result_o.event_res = EV_RDM_DONE;
            count_d = '0;
            mode_d  = MODE_IDLE;
          end else begin
            result_o.event_res = EV_SLOT_STORED;
            count_d = count_inc;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/dmxrdm_out_stage.sv -----
`default_nettype none

module dmxrdm_out_stage
  import dmxrdm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire rx_result_t result_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output rx_result_t      result_o
);

  logic       valid_q, valid_d;
  rx_result_t result_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

// ----- src/dmx_rdm_frame_receiver.sv -----
// a transaction taken on the input is registered in the input stage, then its event in the output stage
// throughput: one byte per cycle unless the output stalls, set by the single framer pass between the registers
// back-pressure from the output stalls the input register only when both stages are full
// reset (asynchronous, active low): mode idle, slot count and rdm length zero, both stages empty,
// configuration registers back to dmx code 0, rdm code 204, 512 slots, rdm minimum 26
`default_nettype none

module dmx_rdm_frame_receiver
  import dmxrdm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]          s_axis_tuser,   // [0] is_break, [1] is_overrun
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [9:0] slot_index, [17:10] slot_data, rest 0
  output logic [2:0]               m_axis_tuser    // [2:0] event_res
);

  rx_item_t   in_item, held_item;
  rx_result_t res_comb, res_out;
  logic       held_valid, out_ready, advance;

  assign in_item = '{rx_byte: s_axis_tdata, is_break: s_axis_tuser[0],
                     is_overrun: s_axis_tuser[1]};
  assign advance = held_valid && out_ready;

  dmxrdm_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (out_ready),
    .item_o  (held_item)
  );

  dmxrdm_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .advance_i  (advance),
    .item_i     (held_item),
    .result_o   (res_comb)
  );

  dmxrdm_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (held_valid),
    .ready_o  (out_ready),
    .result_i (res_comb),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (res_out)
  );

  assign m_axis_tdata = {6'd0, res_out.slot_data, res_out.slot_index};
  assign m_axis_tuser = res_out.event_res;

endmodule

`default_nettype wire

// ----- src/dmxrdm_checker.sv -----
`default_nettype none

module dmxrdm_checker
  import dmxrdm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  logic no_store;

  assign no_store = (m_axis_tuser == EV_IGNORED) || (m_axis_tuser == EV_BREAK_FLUSH) ||
                    (m_axis_tuser == EV_BREAK_IDLE) || (m_axis_tuser == EV_OVERRUN);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result transaction dropped or changed while stalled");

  // the input only backs off when a result is waiting on the output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with the output free");

  a_no_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && no_store |-> m_axis_tdata == 24'd0)
    else $error("event without a stored byte carries payload");

  a_start_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_START_STORED) |-> m_axis_tdata[9:0] == 10'd0)
    else $error("start code not at slot index 0");

  a_slot_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == EV_SLOT_STORED || m_axis_tuser == EV_DMX_DONE)
    |-> m_axis_tdata[9:0] != 10'd0 && m_axis_tdata[9:0] <= 10'd512)
    else $error("data slot index out of range");

endmodule

bind dmx_rdm_frame_receiver dmxrdm_checker u_dmxrdm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import dmxrdm_pkg::*;

  localparam int CycleLimit = 200000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
  logic [1:0]          s_axis_tuser = '0;   // [0] is_break, [1] is_overrun
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [9:0] slot_index, [17:10] slot_data
  logic [2:0]          m_axis_tuser;        // [2:0] event_res

  dmx_rdm_frame_receiver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow of the configuration registers
  logic [7:0]  sh_dmx_code  = DmxStartCodeRst;
  logic [7:0]  sh_rdm_code  = RdmStartCodeRst;
  logic [9:0]  sh_max_slots = MaxSlotsRst;
  logic [8:0]  sh_rdm_min   = RdmMinLenRst;

  // shadow of the framer state
  rx_mode_e    mode_q    = MODE_IDLE;
  logic [9:0]  count_q   = '0;
  logic [7:0]  rdm_len_q = '0;

  rx_result_t  expected_events[$];
  int          errors       = 0;
  int          useful_items = 0;
  int          cycles       = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_left     = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  function automatic rx_result_t predict_event(input rx_item_t it);
    rx_result_t r;
    logic [9:0] idx;
    int         limit;
    r = '0;
    if (it.is_overrun) begin
      r.event_res = EV_OVERRUN;
    end else if (it.is_break) begin
      r.event_res = (count_q != 0) ? EV_BREAK_FLUSH : EV_BREAK_IDLE;
      count_q = '0;
      mode_q  = MODE_START;
    end else begin
      case (mode_q)
        MODE_START: begin
          count_q   = 10'd1;
          rdm_len_q = '0;
          if (it.rx_byte == sh_dmx_code) mode_q = MODE_SLOTS;
          else if (it.rx_byte == sh_rdm_code) mode_q = MODE_RDM;
          else mode_q = MODE_IDLE;
          r.event_res = EV_START_STORED;
          r.slot_data = it.rx_byte;
        end
        MODE_SLOTS: begin
          idx     = count_q;
          count_q = count_q + 10'd1;
          limit   = (sh_max_slots > 512) ? 512 : int'(sh_max_slots);
          r.slot_index = idx;
          r.slot_data  = it.rx_byte;
          if (int'(count_q) > limit) begin
            count_q = '0;
            mode_q  = MODE_IDLE;
            r.event_res = EV_DMX_DONE;
          end else begin
            r.event_res = EV_SLOT_STORED;
          end
        end
        MODE_RDM: begin
          idx     = count_q;
          count_q = count_q + 10'd1;
          if (idx == 10'd2) rdm_len_q = it.rx_byte;
          r.slot_index = idx;
          r.slot_data  = it.rx_byte;
          // length byte plus checksum, and never shorter than the minimum
          if (int'(count_q) >= int'(rdm_len_q) + 2 && int'(count_q) >= int'(sh_rdm_min)) begin
            count_q = '0;
            mode_q  = MODE_IDLE;
            r.event_res = EV_RDM_DONE;
          end else begin
            r.event_res = EV_SLOT_STORED;
          end
        end
        default: r.event_res = EV_IGNORED;
      endcase
    end
    return r;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 10) $display("tb: %s", msg);
  endtask

  // receiver side: random stalls, long hold-off on request, result checking
  initial begin
    rx_result_t want;
    rx_result_t got;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
      @(negedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_res  = event_e'(m_axis_tuser);
        got.slot_index = m_axis_tdata[9:0];
        got.slot_data  = m_axis_tdata[17:10];
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected event %0d index %0d data %02h",
                           got.event_res, got.slot_index, got.slot_data));
        end else begin
          want = expected_events.pop_front();
          if (got.event_res != want.event_res || got.slot_index != want.slot_index ||
              got.slot_data != want.slot_data) begin
            report($sformatf("mismatch event %0d/%0d index %0d/%0d data %02h/%02h (exp/got)",
                             want.event_res, got.event_res, want.slot_index,
                             got.slot_index, want.slot_data, got.slot_data));
          end
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic brk, input logic ovr);
    rx_item_t   it;
    rx_result_t r;
    it.rx_byte    = b;
    it.is_break   = brk;
    it.is_overrun = ovr;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {ovr, brk};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    r = predict_event(it);
    expected_events.push_back(r);
    if (r.event_res != EV_IGNORED) useful_items++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_DMX_START_CODE: sh_dmx_code  = val[7:0];
      CFG_RDM_START_CODE: sh_rdm_code  = val[7:0];
      CFG_MAX_SLOTS:      sh_max_slots = val[9:0];
      default:            sh_rdm_min   = val[8:0];
    endcase
  endtask

  task automatic set_config(input logic [9:0] dmx, input logic [9:0] rdm,
                            input logic [9:0] slots, input logic [9:0] min_len);
    write_reg(CFG_DMX_START_CODE, dmx);
    write_reg(CFG_RDM_START_CODE, rdm);
    write_reg(CFG_MAX_SLOTS, slots);
    write_reg(CFG_RDM_MIN_LENGTH, min_len);
  endtask

  // break, start code, then a body that may stop short of or run past the end
  task automatic send_frame();
    int         pick;
    int         n;
    int         len;
    int         need;
    int         eff;
    int         i;
    logic [7:0] code;
    send_byte(8'($urandom_range(255)), 1'b1, 1'b0);
    pick = $urandom_range(99);
    if (pick < 40) code = sh_dmx_code;
    else if (pick < 80) code = sh_rdm_code;
    else code = 8'($urandom_range(255));
    send_byte(code, 1'b0, 1'b0);
    len = 0;
    if (code == sh_dmx_code) begin
      eff = (sh_max_slots == 0) ? 1 : ((sh_max_slots > 512) ? 512 : int'(sh_max_slots));
      n = $urandom_range(eff + 2, 0);
    end else if (code == sh_rdm_code) begin
      len  = ($urandom_range(19) == 0) ? 255 : $urandom_range(12);
      need = (len + 2 > int'(sh_rdm_min)) ? len + 1 : int'(sh_rdm_min) - 1;
      n = $urandom_range(need + 1, 0);
    end else begin
      n = $urandom_range(3);
    end
    for (i = 1; i <= n; i++) begin
      if ($urandom_range(99) < 4)
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      if (i == 2 && code == sh_rdm_code && code != sh_dmx_code) send_byte(8'(len), 1'b0, 1'b0);
      else send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  task automatic run_random(input int target);
    int start;
    start = useful_items;
    while (useful_items - start < target) begin
      if ($urandom_range(99) < 15)
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_frame();
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    write_reg(CFG_MAX_SLOTS, 10'd3);
    write_reg(CFG_RDM_MIN_LENGTH, 10'd4);
    send_byte(8'hFF, 1'b0, 1'b0);   // idle, ignored
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);   // overrun wins over break
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);   // dmx start
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);   // last slot closes the frame
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'd204, 1'b0, 1'b0);  // rdm start
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b0);   // length byte
    send_byte(8'h10, 1'b0, 1'b0);
    send_byte(8'h20, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);   // unknown start code
    send_byte(8'h66, 1'b0, 1'b0);
    send_byte(8'h00, 1'b1, 1'b0);   // flushes the lone start code
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h42, 1'b0, 1'b0);
    send_byte(8'hC3, 1'b1, 1'b0);
    send_byte(8'd204, 1'b0, 1'b0);
  endtask

  task automatic test_random_phases();
    set_config(10'h000, 10'h0CC, 10'd8, 10'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(30);
    // upper data bits beyond the register width are dropped
    set_config(10'h3FF, 10'h001, 10'd1, 10'd10);
    send_idle_pct = 49;
    stall_pct     = 0;
    run_random(30);
    // equal start codes, dmx takes precedence
    set_config(10'h017, 10'h017, 10'd5, 10'd6);
    send_idle_pct = 0;
    stall_pct     = 49;
    run_random(30);
    set_config(10'($urandom_range(255)), 10'h0CC, 10'd0, 10'd3);
    send_idle_pct = 38;
    stall_pct     = 38;
    run_random(30);
  endtask

  task automatic test_backpressure();
    int i;
    set_config(10'h000, 10'h0CC, 10'd40, 10'd26);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 300;
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    for (i = 0; i < 28; i++) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic test_extremes();
    int i;
    send_idle_pct = 0;
    stall_pct     = 0;
    set_config(10'h000, 10'h0FF, 10'd0, 10'd258);
    // no data slots: the first slot closes the frame
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h7E, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    // longest length byte, minimum written beyond its range still holds
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    for (i = 0; i < 256; i++) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    write_reg(CFG_RDM_MIN_LENGTH, 10'd2);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);   // complete with only one byte after the start code
    send_byte(8'h02, 1'b0, 1'b0);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phases();
    test_backpressure();
    test_extremes();
    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
